/* rtl/core/acl_pkg.sv */
package acl_pkg;

  // Fixed field widths
  localparam int unsigned LAG_W  = 11;
  localparam int unsigned CORR_W = 48;
  localparam int unsigned LEN_CFG_W = 11;
  localparam int unsigned NORM_W = 2;

  // Register indexes (word address)
  localparam logic [2:0] REG_CIRC  = 3'd0;
  localparam logic [2:0] REG_NORM  = 3'd1;
  localparam logic [2:0] REG_LEN   = 3'd2;
  localparam logic [2:0] REG_FIRST = 3'd3;
  localparam logic [2:0] REG_LAST  = 3'd4;

  // Normalization codes
  localparam logic [NORM_W-1:0] NORM_NONE     = 2'd0;
  localparam logic [NORM_W-1:0] NORM_UNBIASED = 2'd1;
  localparam logic [NORM_W-1:0] NORM_BIASED   = 2'd2;

  // Saturation bounds of the result
  localparam logic signed [CORR_W-1:0] CORR_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [CORR_W-1:0] CORR_MIN = ~CORR_MAX;

  // Controller to datapath commands
  typedef struct packed {
    logic wr_sample;   // store one sample, advance fill count
    logic frame_init;  // load first lag, clear lag index
    logic mod_start;   // start first lag modulo frame length
    logic mod_load;    // take circular offset from the divider
    logic lag_init;    // clear accumulator, load read pointers
    logic mac_step;    // issue one pair of reads
    logic norm_start;  // start normalizing division
    logic res_load;    // capture the result beat
    logic lag_next;    // advance to the next lag
  } acl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic frame_full;  // the sample offered completes the frame
    logic range_ok;    // last lag not below first lag
    logic div_done;    // divider result ready
    logic mac_last;    // last read pair of this lag
    logic pipe_busy;   // products still in flight
    logic need_div;    // this lag is normalized by division
    logic lag_last;    // current lag is the last of the frame
  } acl_sts_t;

endpackage

/* rtl/core/autocorrelation_lag_range_top.sv */
// Frame autocorrelation over a programmable lag range.
// Samples enter on the s_axis channel, one beat per cycle while the block
// collects a frame. The beat that completes a frame of N samples starts the
// computation; s_axis_tready stays low until the last result beat is taken.
// For each lag from first_lag to last_lag (at most MAX_LAGS lags) one beat
// leaves on m_axis with the lag and its 48-bit saturated sum; tlast marks
// the last lag. A reversed lag range drops the frame without output.
// Steps per frame: one modulo step, then per lag one setup step, a run on
// the single multiply-accumulate unit (two store reads per cycle), a
// pipeline drain, a pass through the shared bit-serial divider when
// normalizing, and the hand-over of the beat.
// The accumulator width ACC_W is 2*SAMPLE_BITS+log2(MAX_LEN)+1, 43 by default.
// A stalled m_axis holds the result beat and the block waits.
// Reset clears the fill count and sequencer and loads register defaults;
// the frame store is not cleared, it is always written before it is read.
// Registers sit on the APB port at byte address 4*index; pready is always high.
module autocorrelation_lag_range_top #(
  parameter int unsigned MAX_LEN     = 1024,
  parameter int unsigned MAX_LAGS    = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [4:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // sample stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,  // [SAMPLE_BITS-1:0] sample
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [63:0]                       m_axis_tdata,  // [10:0] lag_value, [58:11] corr_value
  output logic                              m_axis_tlast   // run_end
);

  logic                                circ_q;
  logic [acl_pkg::NORM_W-1:0]          norm_q;
  logic [acl_pkg::LEN_CFG_W-1:0]       len_q;
  logic signed [acl_pkg::LAG_W-1:0]    first_q;
  logic signed [acl_pkg::LAG_W-1:0]    last_q;

  logic       wr_en;
  logic [2:0] reg_idx;
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[4:2];

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circ_q  <= 1'b1;
      norm_q  <= acl_pkg::NORM_NONE;
      len_q   <= 11'd500;
      first_q <= -11'sd32;
      last_q  <= 11'sd31;
    end else if (wr_en) begin
      case (reg_idx)
        acl_pkg::REG_CIRC:  circ_q  <= pwdata[0];
        acl_pkg::REG_NORM:  norm_q  <= pwdata[acl_pkg::NORM_W-1:0];
        acl_pkg::REG_LEN:   len_q   <= pwdata[acl_pkg::LEN_CFG_W-1:0];
        acl_pkg::REG_FIRST: first_q <= pwdata[acl_pkg::LAG_W-1:0];
        acl_pkg::REG_LAST:  last_q  <= pwdata[acl_pkg::LAG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      acl_pkg::REG_CIRC:  prdata = {31'd0, circ_q};
      acl_pkg::REG_NORM:  prdata = {30'd0, norm_q};
      acl_pkg::REG_LEN:   prdata = {21'd0, len_q};
      acl_pkg::REG_FIRST: prdata = {21'd0, first_q};
      acl_pkg::REG_LAST:  prdata = {21'd0, last_q};
      default:            prdata = '0;
    endcase
  end

  acl_pkg::acl_cmd_t cmd;
  acl_pkg::acl_sts_t sts;

  acl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  logic signed [acl_pkg::LAG_W-1:0]  res_lag;
  logic signed [acl_pkg::CORR_W-1:0] res_corr;

  acl_dp #(
    .MAX_LEN     (MAX_LEN),
    .MAX_LAGS    (MAX_LAGS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (s_axis_tdata[SAMPLE_BITS-1:0]),
    .circ_i      (circ_q),
    .norm_i      (norm_q),
    .frame_len_i (len_q),
    .first_lag_i (first_q),
    .last_lag_i  (last_q),
    .res_lag_o   (res_lag),
    .res_corr_o  (res_corr),
    .res_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, res_corr, res_lag};

endmodule

/* rtl/core/acl_ram.sv */
module acl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one word, read two registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* rtl/core/acl_div.sv */
module acl_div #(
  parameter int unsigned DIVD_W = 43,
  parameter int unsigned DIVS_W = 11
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DIVD_W-1:0] dividend_i,
  input  logic [DIVS_W-1:0]        divisor_i,
  output logic                     done_o,
  output logic signed [DIVD_W-1:0] quot_o,
  output logic [DIVS_W-1:0]        rem_o
);

  localparam int unsigned CW = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] quo_q, quo_d;
  logic [DIVS_W-1:0] rem_q, rem_d;
  logic [DIVS_W-1:0] dvs_q, dvs_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              neg_q, neg_d;
  logic              done_q, done_d;
  logic [DIVS_W:0]   shifted;

  // One quotient bit per cycle, restoring on magnitudes
  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    shifted = {rem_q, quo_q[DIVD_W-1]};
    if (start_i) begin
      quo_d = dividend_i[DIVD_W-1] ? DIVD_W'(-dividend_i) : dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      neg_d = dividend_i[DIVD_W-1];
      cnt_d = CW'(DIVD_W);
    end else if (cnt_q != '0) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = DIVS_W'(shifted - {1'b0, dvs_q});
        quo_d = {quo_q[DIVD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DIVS_W-1:0];
        quo_d = {quo_q[DIVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(quo_q) : $signed(quo_q);
  assign rem_o  = rem_q;

endmodule

/* rtl/core/acl_ctrl.sv */
module acl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  acl_pkg::acl_sts_t sts_i,
  output acl_pkg::acl_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MODDIV = 7'b0000010,
    S_LAG    = 7'b0000100,
    S_MAC    = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_NORM   = 7'b0100000,
    S_OUT    = 7'b1000000
  } acl_state_e;

  acl_state_e state_q, state_d;

  // Sequence one frame: collect, first lag modulo N, then per lag MAC, normalize if needed, emit
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.wr_sample = 1'b1;
          if (sts_i.frame_full && sts_i.range_ok) begin
            cmd_o.frame_init = 1'b1;
            cmd_o.mod_start  = 1'b1;
            state_d = S_MODDIV;
          end
        end
      end
      S_MODDIV: begin
        if (sts_i.div_done) begin
          cmd_o.mod_load = 1'b1;
          state_d = S_LAG;
        end
      end
      S_LAG: begin
        cmd_o.lag_init = 1'b1;
        state_d = S_MAC;
      end
      S_MAC: begin
        cmd_o.mac_step = 1'b1;
        if (sts_i.mac_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          if (sts_i.need_div) begin
            cmd_o.norm_start = 1'b1;
            state_d = S_NORM;
          end else begin
            cmd_o.res_load = 1'b1;
            state_d = S_OUT;
          end
        end
      end
      S_NORM: begin
        if (sts_i.div_done) begin
          cmd_o.res_load = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (sts_i.lag_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.lag_next = 1'b1;
            state_d = S_LAG;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("controller state not one-hot");

  a_mac_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC) && sts_i.mac_last |=> (state_q == S_DRAIN))
    else $error("MAC run did not end on its last read pair");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) && !out_ready_i |=> (state_q == S_OUT))
    else $error("result beat dropped while stalled");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("sample accepted while a result is pending");

endmodule

/* rtl/core/acl_dp.sv */
module acl_dp #(
  parameter int unsigned MAX_LEN     = 1024,
  parameter int unsigned MAX_LAGS    = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  acl_pkg::acl_cmd_t                   cmd_i,
  output acl_pkg::acl_sts_t                   sts_o,
  input  logic [SAMPLE_BITS-1:0]              sample_i,
  input  logic                                circ_i,
  input  logic [acl_pkg::NORM_W-1:0]          norm_i,
  input  logic [acl_pkg::LEN_CFG_W-1:0]       frame_len_i,
  input  logic signed [acl_pkg::LAG_W-1:0]    first_lag_i,
  input  logic signed [acl_pkg::LAG_W-1:0]    last_lag_i,
  output logic signed [acl_pkg::LAG_W-1:0]    res_lag_o,
  output logic signed [acl_pkg::CORR_W-1:0]   res_corr_o,
  output logic                                res_last_o
);

  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
  localparam int unsigned AW    = $clog2(MAX_LEN);
  localparam int unsigned NW    = (LEN_W > acl_pkg::LEN_CFG_W) ? LEN_W : acl_pkg::LEN_CFG_W;
  localparam int unsigned JW    = NW + 2;
  localparam int unsigned IW    = $clog2(MAX_LAGS + 1);
  localparam int unsigned PW    = 2 * SAMPLE_BITS;
  localparam int unsigned ACC_W = PW + $clog2(MAX_LEN) + 1;
  localparam int unsigned XW    = (ACC_W > acl_pkg::CORR_W) ? ACC_W : acl_pkg::CORR_W;
  localparam int unsigned SPW   = acl_pkg::LAG_W + 1;

  logic [LEN_W-1:0]              fill_q;
  logic [LEN_W-1:0]              i_q;
  logic signed [JW-1:0]          j_q;
  logic [LEN_W-1:0]              k_q;
  logic signed [acl_pkg::LAG_W-1:0] lag_q;
  logic [IW-1:0]                 idx_q;
  logic                          v1_q, v2_q;
  logic signed [PW-1:0]          prod_q;
  logic signed [ACC_W-1:0]       acc_q;

  // Effective frame length, clamped to one and to the store depth
  logic [NW-1:0]    fl_ext;
  logic [LEN_W-1:0] n;
  assign fl_ext = NW'(frame_len_i);
  always_comb begin
    if (fl_ext == '0) begin
      n = LEN_W'(1);
    end else if (fl_ext > NW'(MAX_LEN)) begin
      n = LEN_W'(MAX_LEN);
    end else begin
      n = fl_ext[LEN_W-1:0];
    end
  end

  logic signed [JW-1:0] n_j;
  assign n_j = $signed({{(JW-LEN_W){1'b0}}, n});

  // Lag range and number of results
  logic signed [SPW-1:0] span;
  logic [SPW-1:0]        count;
  assign span  = SPW'(last_lag_i) - SPW'(first_lag_i) + SPW'(1);
  assign count = (span > SPW'(MAX_LAGS)) ? SPW'(MAX_LAGS) : span;

  // Normalization of the current lag
  logic [acl_pkg::LAG_W-1:0] alag;
  logic signed [JW-1:0]      den;
  logic                      den_pos;
  logic                      need_div, zero_res, div_by_n;
  assign alag     = lag_q[acl_pkg::LAG_W-1] ? acl_pkg::LAG_W'(-lag_q) : lag_q;
  assign den      = n_j - $signed(JW'(alag));
  assign den_pos  = !den[JW-1] && (den != '0);
  assign div_by_n = (norm_i == acl_pkg::NORM_BIASED) ||
                    ((norm_i == acl_pkg::NORM_UNBIASED) && circ_i);
  assign zero_res = (norm_i == acl_pkg::NORM_UNBIASED) && !circ_i && !den_pos;
  assign need_div = div_by_n ||
                    ((norm_i == acl_pkg::NORM_UNBIASED) && !circ_i && den_pos);

  // Shared divider: first lag modulo N, then the normalization
  logic                    div_done;
  logic signed [ACC_W-1:0] div_quot;
  logic [LEN_W-1:0]        div_rem;
  logic signed [ACC_W-1:0] div_dvd;
  logic [LEN_W-1:0]        div_dvs;
  assign div_dvd = cmd_i.mod_start ? ACC_W'(first_lag_i) : acc_q;
  assign div_dvs = (cmd_i.mod_start || div_by_n) ? n : den[LEN_W-1:0];

  acl_div #(
    .DIVD_W (ACC_W),
    .DIVS_W (LEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start | cmd_i.norm_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Frame store
  logic [SAMPLE_BITS-1:0] rd_a, rd_b;
  acl_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (cmd_i.wr_sample),
    .waddr_i   (fill_q[AW-1:0]),
    .wdata_i   (sample_i),
    .raddr_a_i (i_q[AW-1:0]),
    .rdata_a_o (rd_a),
    .raddr_b_i (j_q[AW-1:0]),
    .rdata_b_o (rd_b)
  );

  logic frame_full;
  assign frame_full = ({1'b0, fill_q} + (LEN_W+1)'(1)) >= {1'b0, n};

  // Second index in range, or always in circular mode
  logic j_ok;
  assign j_ok = circ_i || (!j_q[JW-1] && (j_q < n_j));

  logic signed [JW-1:0] j_inc;
  assign j_inc = j_q + JW'(1);

  logic [LEN_W-1:0] k_inc;
  assign k_inc = k_q + LEN_W'(1);

  // Fill count, lag and pointer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      idx_q  <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
    end else begin
      if (cmd_i.wr_sample) begin
        fill_q <= frame_full ? '0 : fill_q + LEN_W'(1);
      end
      if (cmd_i.frame_init) begin
        idx_q <= '0;
      end else if (cmd_i.lag_next) begin
        idx_q <= idx_q + IW'(1);
      end
      v1_q <= cmd_i.mac_step && j_ok;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.frame_init) begin
      lag_q <= first_lag_i;
    end else if (cmd_i.lag_next) begin
      lag_q <= lag_q + acl_pkg::LAG_W'(1);
    end
    if (cmd_i.mod_load) begin
      k_q <= (first_lag_i[acl_pkg::LAG_W-1] && (div_rem != '0)) ? n - div_rem : div_rem;
    end else if (cmd_i.lag_next) begin
      k_q <= (k_inc == n) ? '0 : k_inc;
    end
    if (cmd_i.lag_init) begin
      i_q <= '0;
      j_q <= circ_i ? $signed(JW'(k_q)) : JW'(lag_q);
    end else if (cmd_i.mac_step) begin
      i_q <= i_q + LEN_W'(1);
      j_q <= (circ_i && (j_inc == n_j)) ? '0 : j_inc;
    end
    // Multiply, then accumulate
    prod_q <= $signed(rd_a) * $signed(rd_b);
    if (cmd_i.lag_init) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Select, saturate and hold the result beat
  logic signed [ACC_W-1:0] res_val;
  logic signed [XW-1:0]    res_x;
  assign res_val = need_div ? div_quot : (zero_res ? '0 : acc_q);
  assign res_x   = XW'(res_val);

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_lag_o  <= lag_q;
      res_last_o <= (SPW'(idx_q) + SPW'(1)) == count;
      if (res_x > XW'(acl_pkg::CORR_MAX)) begin
        res_corr_o <= acl_pkg::CORR_MAX;
      end else if (res_x < XW'(acl_pkg::CORR_MIN)) begin
        res_corr_o <= acl_pkg::CORR_MIN;
      end else begin
        res_corr_o <= res_x[acl_pkg::CORR_W-1:0];
      end
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.frame_full = frame_full;
    sts_o.range_ok   = (last_lag_i >= first_lag_i);
    sts_o.div_done   = div_done;
    sts_o.mac_last   = (i_q == n - LEN_W'(1));
    sts_o.pipe_busy  = v1_q | v2_q;
    sts_o.need_div   = need_div;
    sts_o.lag_last   = (SPW'(idx_q) + SPW'(1)) == count;
  end

endmodule

/* tb/autocorrelation_lag_range_top_tb.sv */
module autocorrelation_lag_range_top_tb;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned LAG_LIMIT   = 64;
  localparam int unsigned SETTLE_CYC  = 150;
  localparam int unsigned CYCLE_LIMIT = 10000000;

  typedef enum logic [1:0] {OP_SAMPLE, OP_WRITE, OP_DRAIN} op_kind_e;
  typedef enum logic [1:0] {DS_RUN, DS_SETUP, DS_ACCESS, DS_SETTLE} drv_state_e;

  typedef struct {
    op_kind_e    kind;
    logic [2:0]  reg_idx;
    logic [31:0] wdata;
    logic [15:0] sample;
  } stim_op_t;

  typedef struct {
    logic signed [acl_pkg::LAG_W-1:0]  lag;
    logic signed [acl_pkg::CORR_W-1:0] corr;
    logic                              last;
  } corr_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        s_axis_tvalid, s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] sample
  logic        m_axis_tvalid, m_axis_tready;
  logic [63:0] m_axis_tdata;   // [10:0] lag_value, [58:11] corr_value
  logic        m_axis_tlast;   // run_end

  autocorrelation_lag_range_top u_dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always #5 clk_i = ~clk_i;

  stim_op_t   stim_q[$];
  corr_beat_t pending_corr[$];

  // Predictor state
  logic signed [15:0] frame_mem [STORE_DEPTH];
  int                 fill_cnt = 0;
  logic               cfg_circ = 1'b1;
  logic [1:0]         cfg_norm = acl_pkg::NORM_NONE;
  logic [10:0]        cfg_len = 11'd500;
  logic [10:0]        cfg_first = 11'h7E0;
  logic [10:0]        cfg_last = 11'd31;

  int  fail_cnt = 0;
  int  beats_seen = 0;
  int  frames_done = 0;
  int  samples_sent = 0;
  longint cycle_cnt = 0;
  logic quiet;

  // Take one sample; on a full frame, queue one result per lag, none for a reversed range
  task automatic absorb_sample(input logic signed [15:0] smp);
    int n, lo, hi, cnt, lag, k, j;
    longint acc, denom;
    corr_beat_t b;
    n = int'(cfg_len);
    if (n < 1) n = 1;
    if (n > STORE_DEPTH) n = STORE_DEPTH;
    if (fill_cnt < STORE_DEPTH) frame_mem[fill_cnt] = smp;
    fill_cnt++;
    if (fill_cnt < n) return;
    fill_cnt = 0;
    frames_done++;
    lo = int'($signed(cfg_first));
    hi = int'($signed(cfg_last));
    if (hi < lo) return;
    cnt = hi - lo + 1;
    if (cnt > LAG_LIMIT) cnt = LAG_LIMIT;
    for (int li = 0; li < cnt; li++) begin
      lag = lo + li;
      acc = 0;
      if (cfg_circ) begin
        k = lag % n;
        if (k < 0) k += n;
        for (int i = 0; i < n; i++) begin
          j = i + k;
          if (j >= n) j -= n;
          acc += longint'(frame_mem[i]) * longint'(frame_mem[j]);
        end
      end else begin
        for (int i = 0; i < n; i++) begin
          j = i + lag;
          if (j >= 0 && j < n) acc += longint'(frame_mem[i]) * longint'(frame_mem[j]);
        end
      end
      if (cfg_norm == acl_pkg::NORM_UNBIASED) begin
        if (cfg_circ) acc = acc / n;
        else begin
          denom = longint'(n) - (lag < 0 ? -lag : lag);
          acc = (denom > 0) ? acc / denom : 0;
        end
      end else if (cfg_norm == acl_pkg::NORM_BIASED) begin
        acc = acc / n;
      end
      if (acc > longint'(acl_pkg::CORR_MAX)) acc = longint'(acl_pkg::CORR_MAX);
      if (acc < longint'(acl_pkg::CORR_MIN)) acc = longint'(acl_pkg::CORR_MIN);
      b.lag  = lag[acl_pkg::LAG_W-1:0];
      b.corr = acc[acl_pkg::CORR_W-1:0];
      b.last = (li == cnt - 1);
      pending_corr.insert(pending_corr.size(), b);
    end
  endtask

  task automatic push_write(input logic [2:0] idx, input int val);
    stim_op_t op;
    op.kind = OP_WRITE; op.reg_idx = idx; op.wdata = val & 32'h7FF; op.sample = '0;
    stim_q.insert(stim_q.size(), op);
  endtask

  task automatic push_drain();
    stim_op_t op;
    op.kind = OP_DRAIN; op.reg_idx = '0; op.wdata = '0; op.sample = '0;
    stim_q.insert(stim_q.size(), op);
  endtask

  task automatic push_sample(input logic [15:0] val);
    stim_op_t op;
    op.kind = OP_SAMPLE; op.reg_idx = '0; op.wdata = '0; op.sample = val;
    stim_q.insert(stim_q.size(), op);
    samples_sent++;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_setup(input int circ, input int norm, input int len,
                            input int lo, input int hi);
    push_drain();
    push_write(acl_pkg::REG_CIRC, circ);
    push_write(acl_pkg::REG_NORM, norm);
    push_write(acl_pkg::REG_LEN, len);
    push_write(acl_pkg::REG_FIRST, lo);
    push_write(acl_pkg::REG_LAST, hi);
  endtask

  // Driver: samples, register writes and drain pauses
  drv_state_e drv_state;
  int         gap_cnt, settle_cnt;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      paddr <= '0; pwdata <= '0;
      drv_state <= DS_RUN;
      gap_cnt <= 0; settle_cnt <= 0;
      quiet <= 1'b0;
    end else begin
      quiet <= (stim_q.size() < 40);
      case (drv_state)
        DS_SETUP: begin
          penable   <= 1'b1;
          drv_state <= DS_ACCESS;
        end
        DS_ACCESS: begin
          psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
          drv_state <= DS_RUN;
        end
        DS_SETTLE: begin
          // restart the count while any result is still owed
          if (pending_corr.size() != 0) settle_cnt <= SETTLE_CYC;
          else if (settle_cnt == 0) drv_state <= DS_RUN;
          else settle_cnt <= settle_cnt - 1;
        end
        default: begin
          if (s_axis_tvalid && !s_axis_tready) begin
            // hold the beat until taken
          end else if (gap_cnt != 0) begin
            s_axis_tvalid <= 1'b0;
            gap_cnt <= gap_cnt - 1;
          end else if (stim_q.size() == 0) begin
            s_axis_tvalid <= 1'b0;
          end else if (stim_q[0].kind == OP_SAMPLE) begin
            if (!quiet && $urandom_range(0, 7) == 0) begin
              s_axis_tvalid <= 1'b0;
              gap_cnt <= $urandom_range(0, 13);
            end else begin
              s_axis_tvalid <= 1'b1;
              s_axis_tdata  <= stim_q[0].sample;
              void'(stim_q.pop_front());
            end
          end else begin
            s_axis_tvalid <= 1'b0;
            if (stim_q[0].kind == OP_WRITE) begin
              psel <= 1'b1; pwrite <= 1'b1;
              paddr <= {stim_q[0].reg_idx, 2'b00};
              pwdata <= stim_q[0].wdata;
              drv_state <= DS_SETUP;
            end else begin
              settle_cnt <= SETTLE_CYC;
              drv_state  <= DS_SETTLE;
            end
            void'(stim_q.pop_front());
          end
        end
      endcase
    end
  end

  // Receiver ready: random stalls plus one long hold-off
  int  hold_cnt;
  logic held_off;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= 0;
      held_off <= 1'b0;
    end else if (hold_cnt != 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (!held_off && beats_seen >= 30) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= 400;
      held_off <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= $urandom_range(0, 13);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: track register writes, predict on samples, check result beats
  always @(posedge clk_i) begin
    corr_beat_t want;
    if (rst_ni) begin
      cycle_cnt++;
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          acl_pkg::REG_CIRC:  cfg_circ  = pwdata[0];
          acl_pkg::REG_NORM:  cfg_norm  = pwdata[1:0];
          acl_pkg::REG_LEN:   cfg_len   = pwdata[10:0];
          acl_pkg::REG_FIRST: cfg_first = pwdata[10:0];
          acl_pkg::REG_LAST:  cfg_last  = pwdata[10:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) absorb_sample(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        beats_seen++;
        if (pending_corr.size() == 0) begin
          $error("result beat with nothing owed: lag %0d", $signed(m_axis_tdata[10:0]));
          fail_cnt++;
        end else begin
          want = pending_corr.pop_front();
          if (m_axis_tdata[10:0] !== want.lag) begin
            $error("lag_value: expected %0d, got %0d", want.lag, $signed(m_axis_tdata[10:0]));
            fail_cnt++;
          end
          if (m_axis_tdata[58:11] !== want.corr) begin
            $error("corr_value: expected %0d, got %0d", want.corr,
                   $signed(m_axis_tdata[58:11]));
            fail_cnt++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("run_end: expected %0d, got %0d", want.last, m_axis_tlast);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("** autocorrelation_lag_range_top: FAILED **");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    int phase, len, eff, lo, hi, frames;

    // full-scale extremes, circular, no normalization
    push_setup(1, acl_pkg::NORM_NONE, 4, -3, 3);
    push_sample(16'h7FFF); push_sample(16'h8000);
    push_sample(16'h8000); push_sample(16'h7FFF);
    // non-circular unbiased, lags past the frame give zero
    push_setup(0, acl_pkg::NORM_UNBIASED, 4, -5, 5);
    push_sample(16'h0000); push_sample(16'hFFFF);
    push_sample(16'h0001); push_sample(16'h5555);
    // zero frame length acts as one, biased
    push_setup(0, acl_pkg::NORM_BIASED, 0, -2, 2);
    push_sample(16'hAAAA);
    // norm code three behaves as none
    push_setup(1, 3, 3, -4, 4);
    push_sample(16'h8000); push_sample(16'h1234); push_sample(16'h7FFF);
    // reversed range drops the frame
    push_setup(1, acl_pkg::NORM_NONE, 2, 2, 1);
    push_sample(16'h4000); push_sample(16'hC000);
    // frame length lowered while a frame is half full
    push_setup(0, acl_pkg::NORM_UNBIASED, 6, -1, 1);
    push_sample(16'h0101); push_sample(16'hFEFE); push_sample(16'h7F00);
    push_drain();
    push_write(acl_pkg::REG_LEN, 2);
    push_sample(16'h00FF);
    // wide range cut to the lag limit, extreme lags
    push_setup(1, acl_pkg::NORM_UNBIASED, 3, -1023, 1023);
    push_sample(16'h8001); push_sample(16'h7FFE); push_sample(16'h0F0F);

    phase = 0;
    while (samples_sent < 270) begin
      if (phase == 2) begin
        // oversized length clamps to the full store; a lowered length
        // then completes the frame early
        lo = -1023; hi = lo + $urandom_range(0, 63);
        push_setup($urandom_range(0, 1), $urandom_range(0, 3), 2047, lo, hi);
        repeat (5) push_sample(pick_sample());
        push_drain();
        push_write(acl_pkg::REG_LEN, 6);
        push_sample(pick_sample());
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        if ($urandom_range(0, 19) == 0) len = 0;
        eff = (len == 0) ? 1 : len;
        if ($urandom_range(0, 7) == 0) lo = $urandom_range(0, 1) ? -1023 : 990;
        else lo = $urandom_range(0, 40) - 20;
        hi = lo + $urandom_range(0, 70);
        if ($urandom_range(0, 11) == 0) hi = lo - 1 - $urandom_range(0, 3);
        if (hi > 1023) hi = 1023;
        if (hi < -1023) hi = -1023;
        frames = $urandom_range(1, 3);
        push_setup($urandom_range(0, 1), $urandom_range(0, 3), len, lo, hi);
        repeat (frames * eff) push_sample(pick_sample());
      end
      phase++;
    end
    push_drain();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (stim_q.size() != 0 || drv_state != DS_RUN || s_axis_tvalid ||
           pending_corr.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("covered %0d samples in %0d frames over %0d setups, %0d result beats checked",
             samples_sent, frames_done, phase + 7, beats_seen);
    $display("lengths 0 to 40 plus an oversized one, both lag modes, all norm codes, %s",
             "reversed and wide ranges, long receiver stall");
    if (fail_cnt == 0 && pending_corr.size() == 0)
      $display("** autocorrelation_lag_range_top: PASSED **");
    else
      $display("** autocorrelation_lag_range_top: FAILED **");
    $finish;
  end

endmodule
